@@ rtl/i2r_pkg.sv @@
// Shared types, constants and helper functions for the radix digit converter.
package i2r_pkg;

    // Fixed field widths of the channels and the radix register
    localparam int VALUE_W = 32;
    localparam int RADIX_W = 5;
    localparam int CHAR_W  = 7;
    localparam int DIGIT_W = 4;
    localparam int STEP_W  = 2;

    // Radix register limits and reset value
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

    // ASCII anchors for the digit alphabet
    localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'h30;
    localparam logic [CHAR_W-1:0]  CHAR_LETTER = 7'h41;
    localparam logic [DIGIT_W-1:0] DIGIT_LIMIT = 4'd10;

    typedef logic [RADIX_W-1:0] base_t;
    typedef logic [STEP_W-1:0]  step_t;
    typedef logic [DIGIT_W-1:0] digit_t;

    // One queued conversion job: raw value plus its classified base
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        base_t              base;
        step_t              step_top;
    } job_t;

    // Clamp the register contents into the legal base range
    function automatic base_t clamp_radix(input logic [RADIX_W-1:0] r);
        base_t b;
        b = r;
        if (r < RADIX_MIN) b = RADIX_MIN;
        if (r > RADIX_MAX) b = RADIX_MAX;
        return b;
    endfunction

    // Index of the top quotient bit of one digit: bits needed for base - 1, minus one
    function automatic step_t step_top_of(input base_t b);
        step_t s;
        if (b <= 5'd2)      s = 2'd0;
        else if (b <= 5'd4) s = 2'd1;
        else if (b <= 5'd8) s = 2'd2;
        else                s = 2'd3;
        return s;
    endfunction

    // Map a digit value to its ASCII character
    function automatic logic [CHAR_W-1:0] ascii_of(input digit_t d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_LIMIT) c = CHAR_ZERO + CHAR_W'(d);
        else                 c = CHAR_LETTER + CHAR_W'(d - DIGIT_LIMIT);
        return c;
    endfunction

endpackage

@@ rtl/i2r_in_if.sv @@
// Input channel: one value beat per handshake.
interface i2r_in_if
    import i2r_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

@@ rtl/i2r_out_if.sv @@
// Output channel: one ASCII digit beat per handshake.
interface i2r_out_if
    import i2r_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] digit_char;
    logic              last_digit;

    modport source (output valid, output digit_char, output last_digit, input ready);
    modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

@@ rtl/i2r_front.sv @@
// Front end: radix register, input acceptance and base classification.
module i2r_front
    import i2r_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    i2r_in_if.sink             item,
    input  logic               radix_we,
    input  logic [RADIX_W-1:0] radix_wdata,
    output logic               push_valid,
    input  logic               push_ready,
    output job_t               push_job
);

    logic [RADIX_W-1:0] radix_reg;
    base_t              base;

    // Hold the configured radix
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else if (radix_we)
        begin
            radix_reg <= radix_wdata;
        end
    end

    // Classify: clamp the base and derive quotient bits per digit
    assign base = clamp_radix(radix_reg);

    // Forward the beat into the queue
    assign push_valid        = item.valid;
    assign item.ready        = push_ready;
    assign push_job.value    = item.value;
    assign push_job.base     = base;
    assign push_job.step_top = step_top_of(base);

endmodule

@@ rtl/i2r_fifo.sv @@
// Two-entry job queue between the front end and the digit engine.
module i2r_fifo
    import i2r_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_job
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             fifo_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = fifo_mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)      count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push) count_reg <= count_reg - CNT_W'(1);
        end
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            fifo_mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ rtl/i2r_back.sv @@
// Digit engine: builds the power stack, then peels digits most significant first.
module i2r_back
    import i2r_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    job_valid,
    output logic    job_ready,
    input  job_t    job,
    i2r_out_if.source digits
);

    localparam int PTR_W   = $clog2(VALUE_BITS);
    localparam int PROD_W  = VALUE_BITS + RADIX_W;
    localparam int SHIFT_W = VALUE_BITS + (1 << STEP_W) - 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ASC  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    logic [1:0]            state_reg,    state_next;
    logic [VALUE_BITS-1:0] rem_reg,      rem_next;
    logic [VALUE_BITS-1:0] place_reg,    place_next;
    base_t                 base_reg,     base_next;
    step_t                 step_top_reg, step_top_next;
    step_t                 step_reg,     step_next;
    digit_t                q_reg,        q_next;
    logic [PTR_W-1:0]      ptr_reg,      ptr_next;
    logic [PTR_W-1:0]      left_reg,     left_next;

    logic [VALUE_BITS-1:0] stack_mem [VALUE_BITS];
    logic [VALUE_BITS-1:0] stack_rd_reg;
    logic                  stack_we;
    logic [PTR_W-1:0]      stack_waddr;
    logic [VALUE_BITS-1:0] stack_wdata;

    logic                  out_valid_reg;
    logic [CHAR_W-1:0]     out_char_reg;
    logic                  out_last_reg;

    logic [PROD_W-1:0]     prod;
    logic                  asc_go;
    logic [SHIFT_W-1:0]    shifted;
    logic                  cmp;
    logic                  out_free;
    logic                  emit;
    digit_t                digit_val;

    // Next power candidate and the one-bit quotient trial
    assign prod      = PROD_W'(place_reg) * PROD_W'(base_reg);
    assign asc_go    = (prod <= PROD_W'(rem_reg));
    assign shifted   = SHIFT_W'(place_reg) << step_reg;
    assign cmp       = (SHIFT_W'(rem_reg) >= shifted);
    assign out_free  = !out_valid_reg || digits.ready;
    assign digit_val = q_reg | digit_t'(cmp);

    // Sequence ascent, then one quotient bit per cycle; last bits await output
    always_comb
    begin
        state_next    = state_reg;
        rem_next      = rem_reg;
        place_next    = place_reg;
        base_next     = base_reg;
        step_top_next = step_top_reg;
        step_next     = step_reg;
        q_next        = q_reg;
        ptr_next      = ptr_reg;
        left_next     = left_reg;
        stack_we      = 1'b0;
        stack_waddr   = ptr_reg;
        stack_wdata   = prod[VALUE_BITS-1:0];
        emit          = 1'b0;
        job_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                job_ready = 1'b1;
                if (job_valid)
                begin
                    rem_next      = VALUE_BITS'(job.value);
                    place_next    = VALUE_BITS'(1);
                    base_next     = job.base;
                    step_top_next = job.step_top;
                    ptr_next      = '0;
                    stack_we      = 1'b1;
                    stack_waddr   = '0;
                    stack_wdata   = VALUE_BITS'(1);
                    state_next    = ST_ASC;
                end
            end
            ST_ASC:
            begin
                if (asc_go)
                begin
                    // push the next power of the base
                    stack_we    = 1'b1;
                    stack_waddr = ptr_reg + PTR_W'(1);
                    place_next  = prod[VALUE_BITS-1:0];
                    ptr_next    = ptr_reg + PTR_W'(1);
                end
                else
                begin
                    // top power stays in place_reg; prefetch the one below
                    left_next = ptr_reg;
                    if (ptr_reg != '0) ptr_next = ptr_reg - PTR_W'(1);
                    step_next  = step_top_reg;
                    q_next     = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (step_reg != '0 || out_free)
                begin
                    if (cmp) rem_next = rem_reg - shifted[VALUE_BITS-1:0];
                    if (step_reg != '0)
                    begin
                        q_next    = q_reg | (digit_t'(cmp) << step_reg);
                        step_next = step_reg - STEP_W'(1);
                    end
                    else
                    begin
                        emit = 1'b1;
                        if (left_reg == '0)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            // drop to the next lower power
                            place_next = stack_rd_reg;
                            left_next  = left_reg - PTR_W'(1);
                            if (ptr_reg != '0) ptr_next = ptr_reg - PTR_W'(1);
                            step_next  = step_top_reg;
                            q_next     = '0;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            left_reg      <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            left_reg  <= left_next;
            step_reg  <= step_next;
            if (emit)              out_valid_reg <= 1'b1;
            else if (digits.ready) out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        place_reg    <= place_next;
        base_reg     <= base_next;
        step_top_reg <= step_top_next;
        q_reg        <= q_next;
        if (emit)
        begin
            out_char_reg <= ascii_of(digit_val);
            out_last_reg <= (left_reg == '0);
        end
    end

    // Power stack: one write port, registered read that follows the pointer
    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        stack_rd_reg <= stack_mem[ptr_next];
    end

    assign digits.valid      = out_valid_reg;
    assign digits.digit_char = out_char_reg;
    assign digits.last_digit = out_last_reg;

    // Stack pointer stays inside the stack
    assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= PTR_W'(VALUE_BITS - 1))
        else $error("power stack pointer out of range");

    // Remainder is always below base times the current place while peeling
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (PROD_W'(rem_reg) < prod))
        else $error("remainder exceeds digit range");

    // Every emitted digit is a legal digit of the base
    assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (RADIX_W'(digit_val) < base_reg))
        else $error("digit not below base");

    // Prefetch pointer runs one below the remaining digit count
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |->
            (((PTR_W+1)'(left_reg) == (PTR_W+1)'(ptr_reg) + (PTR_W+1)'(1)) ||
             (left_reg == '0 && ptr_reg == '0)))
        else $error("stack prefetch out of step with digit count");

endmodule

@@ rtl/integer_to_radix_digits.sv @@
// Top level of the integer to radix digit converter.
//
//  port         dir   payload                          note
//  item         in    value[31:0]                      one value per beat
//  digits       out   digit_char[6:0], last_digit      one ASCII digit per beat
//  radix_we     in    radix_wdata[4:0]                 base, clamped to 2..16
//
// A value with n digits in a base needing s quotient bits per digit
// (s = 1 for base 2, up to 4 for bases 9..16) is converted in two phases:
// first the stack of base powers is built through the small multiplier, then
// each digit is resolved one quotient bit at a time in the shift-compare-subtract unit.
// Reset clears the control state and sets the radix to 10.
// A stalled digit output holds the engine on a digit's last bit; the two-entry
// queue keeps accepting values meanwhile until it is full.
module integer_to_radix_digits
    import i2r_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    i2r_in_if.sink             item,
    i2r_out_if.source          digits,
    input  logic               radix_we,
    input  logic [RADIX_W-1:0] radix_wdata
);

    logic push_valid;
    logic push_ready;
    job_t push_job;
    logic pop_valid;
    logic pop_ready;
    job_t pop_job;

    i2r_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .radix_we    (radix_we),
        .radix_wdata (radix_wdata),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_job    (push_job)
    );

    i2r_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    i2r_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .job       (pop_job),
        .digits    (digits)
    );

endmodule
